FILE: rtl/pcsb_pkg.sv
package pcsb_pkg;

    localparam int BINS = 64;
    localparam int BIN_W = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    localparam logic signed [15:0] DEPTH_MIN_MM = 16'sd990;
    localparam logic signed [15:0] DEPTH_MAX_MM = 16'sd15000;
    localparam logic [15:0] EMPTY_RANGE_MM = 16'd10000;
    localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;

    localparam logic [2:0] REG_ROW_X = 3'd0;
    localparam logic [2:0] REG_ROW_Y = 3'd1;
    localparam logic [2:0] REG_ROW_Z = 3'd2;
    localparam logic [2:0] REG_HEIGHT_MIN = 3'd3;
    localparam logic [2:0] REG_HEIGHT_MAX = 3'd4;
    localparam logic [2:0] REG_BINS_PER_RADIAN = 3'd5;

    typedef struct packed {
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic signed [15:0] height_min;
        logic signed [15:0] height_max;
        logic [15:0] bins_per_radian;
    } cfg_t;

    // front to back queue entry
    typedef struct packed {
        logic keep;
        logic last;
        logic [BIN_W-1:0] idx;
        logic [31:0] sq;
    } cmd_t;

    function automatic logic signed [31:0] atan_q16(input logic [3:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                4'd0: r = 32'sd51472;
                4'd1: r = 32'sd30386;
                4'd2: r = 32'sd16055;
                4'd3: r = 32'sd8150;
                4'd4: r = 32'sd4091;
                4'd5: r = 32'sd2047;
                4'd6: r = 32'sd1024;
                4'd7: r = 32'sd512;
                4'd8: r = 32'sd256;
                4'd9: r = 32'sd128;
                4'd10: r = 32'sd64;
                4'd11: r = 32'sd32;
                4'd12: r = 32'sd16;
                4'd13: r = 32'sd8;
                4'd14: r = 32'sd4;
                default: r = 32'sd2;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/pcsb_if.sv
interface pcsb_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic last_point;
    modport source (output valid, px, py, pz, last_point, input ready);
    modport sink (input valid, px, py, pz, last_point, output ready);
endinterface

interface pcsb_out_if;
    logic valid;
    logic ready;
    logic [5:0] bin_index;
    logic [15:0] range_mm;
    logic last_bin;
    modport source (output valid, bin_index, range_mm, last_bin, input ready);
    modport sink (input valid, bin_index, range_mm, last_bin, output ready);
endinterface

FILE: rtl/pcsb_front.sv
module pcsb_front (
    input  logic clk,
    input  logic rst_n,
    input  pcsb_pkg::cfg_t cfg,
    pcsb_in_if.sink in_ch,
    output logic cmd_valid,
    output pcsb_pkg::cmd_t cmd,
    input  logic cmd_ready
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_XFORM = 7'b0000100,
        S_PRE   = 7'b0001000,
        S_CORD  = 7'b0010000,
        S_IDX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic last_reg, inband_reg;
    logic [1:0] row_sel_reg;
    logic signed [33:0] acc_reg;
    logic signed [31:0] xv_reg, yv_reg, zv_reg;
    logic signed [31:0] cx_reg, cy_reg, ang_reg;
    logic [3:0] it_reg;
    logic [63:0] sq_reg;
    logic signed [49:0] t_reg;

    logic [63:0] row;
    logic signed [33:0] prod;
    logic signed [31:0] coord;
    logic signed [31:0] cxs, cys;
    logic signed [19:0] xn, yn, zn;
    logic signed [39:0] xsq, ysq, zsq;
    logic t_ok;
    logic keep_c;

    always_comb
    begin
        case (row_sel_reg)
            2'd0: row = cfg.row_x;
            2'd1: row = cfg.row_y;
            default: row = cfg.row_z;
        endcase
    end

    assign prod = 34'(signed'(row[15:0]) * px_reg) + 34'(signed'(row[31:16]) * py_reg)
                + 34'(signed'(row[47:32]) * pz_reg);
    assign coord = 32'((acc_reg + 34'sd8192) >>> 14) + 32'(signed'(row[63:48]));
    assign cxs = cx_reg >>> it_reg;
    assign cys = cy_reg >>> it_reg;

    // transformed coordinates stay within 20 bits signed
    assign xn = xv_reg[19:0];
    assign yn = yv_reg[19:0];
    assign zn = zv_reg[19:0];
    assign xsq = xn * xn;
    assign ysq = yn * yn;
    assign zsq = zn * zn;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cmd_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = S_MUL;
            S_MUL:   state_next = S_XFORM;
            S_XFORM: state_next = (row_sel_reg == 2'd2) ? S_PRE : S_MUL;
            S_PRE:   state_next = S_CORD;
            S_CORD:  if (it_reg == 4'd15) state_next = S_IDX;
            S_IDX:   state_next = S_OUT;
            S_OUT:   if (cmd_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                px_reg <= in_ch.px;
                py_reg <= in_ch.py;
                pz_reg <= in_ch.pz;
                last_reg <= in_ch.last_point;
                row_sel_reg <= 2'd0;
                inband_reg <= (in_ch.pz >= pcsb_pkg::DEPTH_MIN_MM)
                           && (in_ch.pz <= pcsb_pkg::DEPTH_MAX_MM);
            end
            S_MUL: acc_reg <= prod;
            S_XFORM:
            begin
                case (row_sel_reg)
                    2'd0: xv_reg <= coord;
                    2'd1: yv_reg <= coord;
                    default: zv_reg <= coord;
                endcase
                row_sel_reg <= row_sel_reg + 2'd1;
            end
            S_PRE:
            begin
                it_reg <= 4'd0;
                sq_reg <= 64'(xsq) + 64'(ysq);
                if (zv_reg < 0)
                begin
                    if (yv_reg >= 0)
                    begin
                        cx_reg <= yv_reg <<< 8;
                        cy_reg <= (-zv_reg) <<< 8;
                        ang_reg <= pcsb_pkg::HALF_PI_Q16;
                    end
                    else
                    begin
                        cx_reg <= (-yv_reg) <<< 8;
                        cy_reg <= zv_reg <<< 8;
                        ang_reg <= -pcsb_pkg::HALF_PI_Q16;
                    end
                end
                else
                begin
                    cx_reg <= zv_reg <<< 8;
                    cy_reg <= yv_reg <<< 8;
                    ang_reg <= '0;
                end
            end
            S_CORD:
            begin
                it_reg <= it_reg + 4'd1;
                if (it_reg == 4'd0)
                    sq_reg <= sq_reg + 64'(zsq);
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + cys;
                    cy_reg <= cy_reg - cxs;
                    ang_reg <= ang_reg + pcsb_pkg::atan_q16(it_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - cys;
                    cy_reg <= cy_reg + cxs;
                    ang_reg <= ang_reg - pcsb_pkg::atan_q16(it_reg);
                end
            end
            S_IDX:
            begin
                if (zv_reg == 0 && yv_reg == 0)
                    t_reg <= 50'(pcsb_pkg::BINS) <<< 23;
                else
                    t_reg <= 50'($signed({1'b0, cfg.bins_per_radian}) * ang_reg)
                           + (50'(pcsb_pkg::BINS) <<< 23);
            end
            default: ;
        endcase
    end

    // command is built from registers that hold still during S_OUT
    assign t_ok = (t_reg < 0) ? (t_reg > -50'sd16777216)
                              : (t_reg[49:24] < 26'(pcsb_pkg::BINS));
    assign keep_c = inband_reg && (xv_reg < 32'(cfg.height_max))
                 && (xv_reg > 32'(cfg.height_min)) && t_ok;

    always_comb
    begin
        cmd.keep = keep_c;
        cmd.last = last_reg;
        cmd.idx = (t_reg < 0) ? '0 : t_reg[24 +: pcsb_pkg::BIN_W];
        cmd.sq = (sq_reg[63:32] != '0) ? 32'hFFFFFFFF : sq_reg[31:0];
    end

endmodule

FILE: rtl/pcsb_back.sv
module pcsb_back (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  pcsb_pkg::cmd_t cmd,
    output logic cmd_ready,
    pcsb_out_if.source out_ch
);
    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_UPD  = 6'b000010,
        B_RD   = 6'b000100,
        B_LD   = 6'b001000,
        B_SQRT = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t st_reg;
    logic [31:0] mem [pcsb_pkg::BINS];
    logic [pcsb_pkg::BINS-1:0] hit_reg;
    logic [31:0] rd_reg;
    pcsb_pkg::cmd_t cmd_reg;
    logic [pcsb_pkg::BIN_W-1:0] cnt_reg;
    logic [31:0] v_reg, res_reg, bit_reg;
    logic [15:0] carry_reg;
    logic [5:0] bi_reg;
    logic lb_reg;
    logic was_hit_reg;
    logic [pcsb_pkg::BIN_W-1:0] rd_addr;
    logic upd;

    assign cmd_ready = (st_reg == B_IDLE);
    assign out_ch.valid = (st_reg == B_OUT);
    assign out_ch.bin_index = bi_reg;
    assign out_ch.range_mm = carry_reg;
    assign out_ch.last_bin = lb_reg;

    // single read port: the incoming bin while idle, the sweep counter otherwise
    assign rd_addr = (st_reg == B_IDLE) ? cmd.idx : cnt_reg;
    assign upd = (st_reg == B_UPD) && cmd_reg.keep
              && (!hit_reg[cmd_reg.idx] || cmd_reg.sq < rd_reg);

    always_ff @(posedge clk)
    begin
        if (upd)
            mem[cmd_reg.idx] <= cmd_reg.sq;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            hit_reg <= '0;
            cmd_reg <= '0;
            cnt_reg <= '0;
            v_reg <= '0;
            res_reg <= '0;
            bit_reg <= '0;
            carry_reg <= pcsb_pkg::EMPTY_RANGE_MM;
            bi_reg <= '0;
            lb_reg <= 1'b0;
            was_hit_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                B_IDLE:
                if (cmd_valid)
                begin
                    cmd_reg <= cmd;
                    st_reg <= B_UPD;
                end
                B_UPD:
                begin
                    if (upd)
                        hit_reg[cmd_reg.idx] <= 1'b1;
                    if (cmd_reg.last)
                    begin
                        cnt_reg <= '0;
                        carry_reg <= pcsb_pkg::EMPTY_RANGE_MM;
                        st_reg <= B_RD;
                    end
                    else
                        st_reg <= B_IDLE;
                end
                B_RD: st_reg <= B_LD;
                B_LD:
                begin
                    was_hit_reg <= hit_reg[cnt_reg];
                    v_reg <= rd_reg;
                    res_reg <= '0;
                    bit_reg <= 32'h40000000;
                    st_reg <= B_SQRT;
                end
                B_SQRT:
                begin
                    if (!was_hit_reg || bit_reg == '0)
                    begin
                        if (was_hit_reg)
                            carry_reg <= res_reg[15:0];
                        bi_reg <= cnt_reg;
                        lb_reg <= (cnt_reg == 6'(pcsb_pkg::BINS - 1));
                        st_reg <= B_OUT;
                    end
                    else
                    begin
                        if (v_reg >= res_reg + bit_reg)
                        begin
                            v_reg <= v_reg - (res_reg + bit_reg);
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                B_OUT:
                if (out_ch.ready)
                begin
                    if (lb_reg)
                    begin
                        hit_reg <= '0;
                        st_reg <= B_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        st_reg <= B_RD;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/point_cloud_to_scan_binner_top.sv
// Front: takes a new point only when idle, after transform, CORDIC, setup, index and handoff of the last.
// The bin sweep starts once the back has taken a command marked as the last point.
// Sweep end: 64 bin beats; a filled bin passes through an integer square root first.
// A 4-entry queue lets the front keep taking points while the back emits a sweep, until it fills.
// Reset: rst_n async active low; registers to defaults, bins empty, queue empty.
module point_cloud_to_scan_binner_top (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    pcsb_in_if.sink in_ch,
    pcsb_out_if.source out_ch
);
    pcsb_pkg::cfg_t cfg_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    pcsb_pkg::cmd_t f_cmd, b_cmd;
    pcsb_pkg::cmd_t q_mem [pcsb_pkg::QUEUE_DEPTH];
    logic [pcsb_pkg::QUEUE_AW-1:0] q_wr_reg, q_rd_reg;
    logic [pcsb_pkg::QUEUE_AW:0] q_cnt_reg;
    logic q_push, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_x <= 64'd16384;
            cfg_reg.row_y <= 64'd1073741824;
            cfg_reg.row_z <= 64'd70368744177664;
            cfg_reg.height_min <= 16'sh8000;
            cfg_reg.height_max <= 16'sd32767;
            cfg_reg.bins_per_radian <= 16'd5215;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcsb_pkg::REG_ROW_X: cfg_reg.row_x <= cfg_data;
                pcsb_pkg::REG_ROW_Y: cfg_reg.row_y <= cfg_data;
                pcsb_pkg::REG_ROW_Z: cfg_reg.row_z <= cfg_data;
                pcsb_pkg::REG_HEIGHT_MIN: cfg_reg.height_min <= cfg_data[15:0];
                pcsb_pkg::REG_HEIGHT_MAX: cfg_reg.height_max <= cfg_data[15:0];
                pcsb_pkg::REG_BINS_PER_RADIAN: cfg_reg.bins_per_radian <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front to back queue
    assign f_ready = !q_cnt_reg[pcsb_pkg::QUEUE_AW];
    assign b_valid = (q_cnt_reg != '0);
    assign b_cmd = q_mem[q_rd_reg];
    assign q_push = f_valid && f_ready;
    assign q_pop = b_valid && b_ready;

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wr_reg] <= f_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg <= '0;
            q_rd_reg <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                q_wr_reg <= q_wr_reg + 1'b1;
            if (q_pop)
                q_rd_reg <= q_rd_reg + 1'b1;
            if (q_push && !q_pop)
                q_cnt_reg <= q_cnt_reg + 1'b1;
            else if (!q_push && q_pop)
                q_cnt_reg <= q_cnt_reg - 1'b1;
        end
    end

    pcsb_front u_front (.clk, .rst_n, .cfg(cfg_reg), .in_ch,
                        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready));
    pcsb_back u_back (.clk, .rst_n, .cmd_valid(b_valid), .cmd(b_cmd),
                      .cmd_ready(b_ready), .out_ch);

`ifndef SYNTHESIS
    a_last_bin_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_bin |-> out_ch.bin_index == 6'(pcsb_pkg::BINS - 1))
        else $error("last_bin on wrong bin");
    a_no_cmd_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !b_ready)
        else $error("back accepts while emitting");
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 3'(pcsb_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule
